>>> rtl/ifrt_pkg.sv
package ifrt_pkg;

   localparam int SLOT_BITS   = 10;
   localparam int SLOTS       = 1 << SLOT_BITS;
   localparam int PROBE_DEPTH = 8;
   localparam int PROBE_BITS  = $clog2(PROBE_DEPTH + 1);
   localparam int WORD_BITS   = 7;
   localparam int SLOT_WORDS  = 1 << WORD_BITS;
   localparam int BM_BITS     = SLOT_BITS + WORD_BITS;

   localparam logic [31:0] TIMEOUT_RESET = 32'd2000;

   localparam logic [2:0] ST_PROGRESS = 3'd0;
   localparam logic [2:0] ST_COMPLETE = 3'd1;
   localparam logic [2:0] ST_NOSLOT   = 3'd2;
   localparam logic [2:0] ST_BOUNDS   = 3'd3;
   localparam logic [2:0] ST_OVERLAP  = 3'd4;

   typedef struct packed {
      logic        active;
      logic [31:0] source;
      logic [15:0] ident;
      logic [31:0] stamp;
      logic        have_first;
      logic        have_last;
      logic [15:0] exp_len;
   } slot_meta_type;

   typedef struct packed {
      logic [5:0] start;
      logic [6:0] count;
   } word_span_type;

endpackage

>>> rtl/ifrt_if.sv
interface ifrt_req_if;
   import ifrt_pkg::*;
   logic        valid;
   logic        ready;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [15:0] ip_id;
   logic [7:0]  protocol;
   logic [3:0]  header_words;
   logic [15:0] total_length;
   logic [12:0] frag_offset;
   logic        more_fragments;
   logic [31:0] now_ms;
   modport source (output valid, src_addr, dst_addr, ip_id, protocol, header_words,
                   total_length, frag_offset, more_fragments, now_ms, input ready);
   modport sink (input valid, src_addr, dst_addr, ip_id, protocol, header_words,
                 total_length, frag_offset, more_fragments, now_ms, output ready);
endinterface

interface ifrt_rsp_if;
   import ifrt_pkg::*;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [9:0]  slot_index;
   logic [15:0] datagram_length;
   logic [31:0] completed_count;
   logic [31:0] timeout_count;
   logic [31:0] bounds_error_count;
   logic [31:0] overlap_count;
   modport source (output valid, status, slot_index, datagram_length, completed_count,
                   timeout_count, bounds_error_count, overlap_count, input ready);
   modport sink (input valid, status, slot_index, datagram_length, completed_count,
                 timeout_count, bounds_error_count, overlap_count, output ready);
endinterface

>>> rtl/ifrt_word_unit.sv
module ifrt_word_unit
   import ifrt_pkg::*;
(
   input  logic [63:0]   word,
   input  word_span_type span,
   output logic [63:0]   merged,
   output logic          any_hit,
   output logic          all_set
);

   logic [63:0] mask;
   logic [7:0]  stop;

   always_comb begin
      stop = {2'b00, span.start} + {1'b0, span.count};
      for (int k = 0; k < 64; k++) begin
         mask[k] = (8'(k) >= {2'b00, span.start}) && (8'(k) < stop);
      end
      merged  = word | mask;
      any_hit = |(word & mask);
      all_set = (word & mask) == mask;
   end

endmodule

>>> rtl/ipv4_fragment_reassembly_tracker_top.sv
// Steps per beat: probe the slots in turn (read, check), wipe all 128 bitmap words of a claimed
// slot, check bounds, mark each covered bitmap word (read, write), decide, check each word for
// completion (read, check), then commit and load the result once the result register is free.
// Throughput: one fragment at a time; req is ready again the cycle after the result loads.
// Reset: synchronous; a pass over all 1024 slots then clears the slot table, with req not ready.
module ipv4_fragment_reassembly_tracker_top
   import ifrt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   ifrt_req_if.sink     req,
   ifrt_rsp_if.source   rsp,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data
);

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_PROBE_RD  = 4'd2;
   localparam logic [3:0] S_PROBE_CHK = 4'd3;
   localparam logic [3:0] S_WIPE      = 4'd4;
   localparam logic [3:0] S_BOUNDS    = 4'd5;
   localparam logic [3:0] S_MARK_RD   = 4'd6;
   localparam logic [3:0] S_MARK_WR   = 4'd7;
   localparam logic [3:0] S_DECIDE    = 4'd8;
   localparam logic [3:0] S_COV_RD    = 4'd9;
   localparam logic [3:0] S_COV_CHK   = 4'd10;
   localparam logic [3:0] S_COMMIT    = 4'd11;
   localparam logic [3:0] S_DONE      = 4'd12;

   slot_meta_type meta_mem [SLOTS];
   logic [63:0]   bm_mem [SLOTS * SLOT_WORDS];

   logic [3:0]  state_ff, state_in;
   logic [31:0] timeout_ff, timeout_in;
   logic [SLOT_BITS-1:0] clr_ff, clr_in;
   logic [31:0] src_ff, now_ff;
   logic [15:0] id_ff, tot_ff;
   logic [3:0]  hdr_ff;
   logic [12:0] foff_ff;
   logic        mf_ff;
   logic [SLOT_BITS-1:0]  home_ff, home_in, slot_ff, slot_in;
   logic [PROBE_BITS-1:0] probe_ff, probe_in;
   slot_meta_type meta_ff, meta_in, meta_rd_ff;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [7:0]  cov_ff, cov_in;
   logic [5:0]  start_ff, start_in;
   logic [13:0] rem_ff, rem_in;
   logic        hit_ff, hit_in;
   logic [2:0]  status_ff, status_in;
   logic [15:0] dlen_ff, dlen_in;
   logic [31:0] cnt_done_ff, cnt_done_in, cnt_tmo_ff, cnt_tmo_in;
   logic [31:0] cnt_bnd_ff, cnt_bnd_in, cnt_ovl_ff, cnt_ovl_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff;
   logic [9:0]  rsp_slot_ff;
   logic [15:0] rsp_dlen_ff;
   logic [31:0] rsp_done_ff, rsp_tmo_ff, rsp_bnd_ff, rsp_ovl_ff;
   logic [63:0] bm_rd_ff;

   logic        accept, rsp_load, meta_we, bm_we;
   logic [SLOT_BITS-1:0] probe_addr, meta_waddr;
   slot_meta_type meta_wdata;
   logic [63:0] bm_wdata, merged;
   logic        any_hit, all_set;
   word_span_type span;
   logic [31:0] key;
   logic [16:0] plen, end_pos, cov_sum;
   logic [13:0] nblk, bits;
   logic [7:0]  full_w, nw;
   logic [6:0]  avail, chunk;
   logic        first_n, last_n;
   logic [15:0] exp_n;
   logic [16:0] exp_sum;
   logic [7:0]  nw_n;

   ifrt_word_unit u_word (
      .word    (bm_rd_ff),
      .span    (span),
      .merged  (merged),
      .any_hit (any_hit),
      .all_set (all_set)
   );

   assign accept     = req.valid && req.ready;
   assign req.ready  = (state_ff == S_IDLE);
   assign key        = req.src_addr ^ req.dst_addr ^ {16'd0, req.ip_id} ^ {24'd0, req.protocol};
   assign probe_addr = home_ff + SLOT_BITS'(probe_ff);

   // payload geometry of the held fragment
   assign plen    = {1'b0, tot_ff} - {11'd0, hdr_ff, 2'b00};
   assign end_pos = {1'b0, foff_ff, 3'b000} + plen;
   assign nblk    = 14'((plen + 17'd7) >> 3);
   assign avail   = 7'd64 - {1'b0, start_ff};
   assign chunk   = (rem_ff < {7'd0, avail}) ? rem_ff[6:0] : avail;

   // completion geometry of the slot
   assign cov_sum = {1'b0, meta_ff.exp_len} + 17'd7;
   assign bits    = cov_sum[16:3];
   assign full_w  = bits[13:6];
   assign nw      = full_w + {7'd0, (bits[5:0] != 6'd0)};

   assign first_n = meta_ff.have_first || (foff_ff == 13'd0);
   assign last_n  = meta_ff.have_last || !mf_ff;
   assign exp_n   = mf_ff ? meta_ff.exp_len : end_pos[15:0];
   assign exp_sum = {1'b0, exp_n} + 17'd7;
   assign nw_n    = exp_sum[16:9] + {7'd0, (exp_sum[8:3] != 6'd0)};

   always_comb begin
      if (state_ff == S_COV_CHK) begin
         span.start = 6'd0;
         span.count = (cov_ff == full_w) ? {1'b0, bits[5:0]} : 7'd64;
      end else begin
         span.start = start_ff;
         span.count = chunk;
      end
   end

   assign meta_we    = (state_ff == S_CLEAR) || (state_ff == S_COMMIT);
   assign meta_waddr = (state_ff == S_CLEAR) ? clr_ff : slot_ff;
   assign meta_wdata = (state_ff == S_CLEAR) ? '0 : meta_ff;
   assign bm_we      = (state_ff == S_WIPE) || (state_ff == S_MARK_WR);
   assign bm_wdata   = (state_ff == S_WIPE) ? 64'd0 : merged;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in    = state_ff;
      timeout_in  = csr_wr_en ? csr_wr_data : timeout_ff;
      clr_in      = clr_ff;
      home_in     = home_ff;
      slot_in     = slot_ff;
      probe_in    = probe_ff;
      meta_in     = meta_ff;
      word_in     = word_ff;
      cov_in      = cov_ff;
      start_in    = start_ff;
      rem_in      = rem_ff;
      hit_in      = hit_ff;
      status_in   = status_ff;
      dlen_in     = dlen_ff;
      cnt_done_in = cnt_done_ff;
      cnt_tmo_in  = cnt_tmo_ff;
      cnt_bnd_in  = cnt_bnd_ff;
      cnt_ovl_in  = cnt_ovl_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SLOT_BITS'(SLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               home_in  = key[SLOT_BITS-1:0];
               probe_in = '0;
               state_in = S_PROBE_RD;
            end
         end
         S_PROBE_RD: state_in = S_PROBE_CHK;
         S_PROBE_CHK: begin
            slot_in = probe_addr;
            if (meta_rd_ff.active && meta_rd_ff.ident == id_ff &&
                meta_rd_ff.source == src_ff) begin
               meta_in       = meta_rd_ff;
               meta_in.stamp = now_ff;
               state_in      = S_BOUNDS;
            end else if (!meta_rd_ff.active || (now_ff - meta_rd_ff.stamp) > timeout_ff) begin
               if (meta_rd_ff.active) cnt_tmo_in = cnt_tmo_ff + 1'b1;
               meta_in  = '{active: 1'b1, source: src_ff, ident: id_ff, stamp: now_ff,
                            have_first: 1'b0, have_last: 1'b0, exp_len: 16'd0};
               word_in  = '0;
               state_in = S_WIPE;
            end else if (probe_ff == PROBE_BITS'(PROBE_DEPTH - 1)) begin
               slot_in   = '0;
               status_in = ST_NOSLOT;
               dlen_in   = 16'd0;
               state_in  = S_DONE;
            end else begin
               probe_in = probe_ff + 1'b1;
               state_in = S_PROBE_RD;
            end
         end
         S_WIPE: begin
            word_in = word_ff + 1'b1;
            if (word_ff == WORD_BITS'(SLOT_WORDS - 1)) state_in = S_BOUNDS;
         end
         S_BOUNDS: begin
            dlen_in  = 16'd0;
            hit_in   = 1'b0;
            word_in  = foff_ff[12:6];
            start_in = foff_ff[5:0];
            rem_in   = nblk;
            if (plen[16] || end_pos[16]) begin
               cnt_bnd_in     = cnt_bnd_ff + 1'b1;
               meta_in.active = 1'b0;
               status_in      = ST_BOUNDS;
               state_in       = S_COMMIT;
            end else if (nblk == 14'd0) begin
               state_in = S_DECIDE;
            end else begin
               state_in = S_MARK_RD;
            end
         end
         S_MARK_RD: state_in = S_MARK_WR;
         S_MARK_WR: begin
            hit_in   = hit_ff || any_hit;
            rem_in   = rem_ff - {7'd0, chunk};
            word_in  = word_ff + 1'b1;
            start_in = 6'd0;
            state_in = (rem_ff == {7'd0, chunk}) ? S_DECIDE : S_MARK_RD;
         end
         S_DECIDE: begin
            word_in = '0;
            cov_in  = 8'd0;
            if (hit_ff) begin
               cnt_ovl_in     = cnt_ovl_ff + 1'b1;
               meta_in.active = 1'b0;
               status_in      = ST_OVERLAP;
               state_in       = S_COMMIT;
            end else begin
               meta_in.have_first = first_n;
               meta_in.have_last  = last_n;
               meta_in.exp_len    = exp_n;
               status_in          = ST_PROGRESS;
               state_in           = S_COMMIT;
               if (first_n && last_n) begin
                  if (nw_n == 8'd0) begin
                     cnt_done_in    = cnt_done_ff + 1'b1;
                     meta_in.active = 1'b0;
                     dlen_in        = exp_n;
                     status_in      = ST_COMPLETE;
                  end else begin
                     state_in = S_COV_RD;
                  end
               end
            end
         end
         S_COV_RD: state_in = S_COV_CHK;
         S_COV_CHK: begin
            if (!all_set) begin
               state_in = S_COMMIT;
            end else if (cov_ff + 8'd1 == nw) begin
               cnt_done_in    = cnt_done_ff + 1'b1;
               meta_in.active = 1'b0;
               dlen_in        = meta_ff.exp_len;
               status_in      = ST_COMPLETE;
               state_in       = S_COMMIT;
            end else begin
               cov_in   = cov_ff + 8'd1;
               word_in  = word_ff + 1'b1;
               state_in = S_COV_RD;
            end
         end
         S_COMMIT: state_in = S_DONE;
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         timeout_ff   <= TIMEOUT_RESET;
         clr_ff       <= '0;
         cnt_done_ff  <= '0;
         cnt_tmo_ff   <= '0;
         cnt_bnd_ff   <= '0;
         cnt_ovl_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         clr_ff       <= clr_in;
         cnt_done_ff  <= cnt_done_in;
         cnt_tmo_ff   <= cnt_tmo_in;
         cnt_bnd_ff   <= cnt_bnd_in;
         cnt_ovl_ff   <= cnt_ovl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // dst and protocol only feed the hash at accept
   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff   <= req.src_addr;
         id_ff    <= req.ip_id;
         hdr_ff   <= req.header_words;
         tot_ff   <= req.total_length;
         foff_ff  <= req.frag_offset;
         mf_ff    <= req.more_fragments;
         now_ff   <= req.now_ms;
      end
      home_ff   <= home_in;
      slot_ff   <= slot_in;
      probe_ff  <= probe_in;
      meta_ff   <= meta_in;
      word_ff   <= word_in;
      cov_ff    <= cov_in;
      start_ff  <= start_in;
      rem_ff    <= rem_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      dlen_ff   <= dlen_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_slot_ff   <= slot_ff[9:0];
         rsp_dlen_ff   <= dlen_ff;
         rsp_done_ff   <= cnt_done_ff;
         rsp_tmo_ff    <= cnt_tmo_ff;
         rsp_bnd_ff    <= cnt_bnd_ff;
         rsp_ovl_ff    <= cnt_ovl_ff;
      end
   end

   // slot table
   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
      meta_rd_ff <= meta_mem[probe_addr];
   end

   // reassembly bitmap, one row of words per slot
   always_ff @(posedge clock) begin
      if (bm_we) bm_mem[{slot_ff, word_ff}] <= bm_wdata;
      bm_rd_ff <= bm_mem[{slot_ff, word_ff}];
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.status             = rsp_status_ff;
   assign rsp.slot_index         = rsp_slot_ff;
   assign rsp.datagram_length    = rsp_dlen_ff;
   assign rsp.completed_count    = rsp_done_ff;
   assign rsp.timeout_count      = rsp_tmo_ff;
   assign rsp.bounds_error_count = rsp_bnd_ff;
   assign rsp.overlap_count      = rsp_ovl_ff;

endmodule

>>> tb/tb_top.sv
module tb_top;
   import ifrt_pkg::*;

   typedef struct {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] ip_id;
      logic [7:0]  protocol;
      logic [3:0]  header_words;
      logic [15:0] total_length;
      logic [12:0] frag_offset;
      logic        more_fragments;
      logic [31:0] now_ms;
   } fragment_type;

   typedef struct {
      logic [2:0]  status;
      logic [9:0]  slot_index;
      logic [15:0] datagram_length;
      logic [31:0] completed_count;
      logic [31:0] timeout_count;
      logic [31:0] bounds_error_count;
      logic [31:0] overlap_count;
   } verdict_type;

   class reassembly_scoreboard;
      bit [31:0] timeout_ms;
      bit        active [SLOTS];
      bit [31:0] source [SLOTS];
      bit [15:0] ident [SLOTS];
      bit [31:0] stamp [SLOTS];
      bit        have_first [SLOTS];
      bit        have_last [SLOTS];
      bit [15:0] exp_len [SLOTS];
      bit [63:0] blocks [SLOTS*SLOT_WORDS];
      bit [31:0] n_complete, n_timeout, n_bounds, n_overlap;
      verdict_type verdict_q [$];
      int        errors;

      function new();
         timeout_ms = TIMEOUT_RESET;
      endfunction

      function int find_slot(fragment_type f);
         int home;
         int s;
         home = int'((f.src_addr ^ f.dst_addr ^ {16'd0, f.ip_id} ^ {24'd0, f.protocol})
                     % SLOTS);
         for (int i = 0; i < PROBE_DEPTH; i++) begin
            s = (home + i) % SLOTS;
            if (active[s] && ident[s] == f.ip_id && source[s] == f.src_addr) begin
               stamp[s] = f.now_ms;
               return s;
            end
            if (!active[s] || (f.now_ms - stamp[s]) > timeout_ms) begin
               if (active[s]) n_timeout++;
               active[s] = 1;
               source[s] = f.src_addr;
               ident[s] = f.ip_id;
               stamp[s] = f.now_ms;
               have_first[s] = 0;
               have_last[s] = 0;
               exp_len[s] = 0;
               for (int w = 0; w < SLOT_WORDS; w++) blocks[s*SLOT_WORDS + w] = '0;
               return s;
            end
         end
         return -1;
      endfunction

      function bit covered(int s, int len);
         int bits;
         int full;
         int rest;
         bit [63:0] m;
         bits = (len + 7) / 8;
         full = bits / 64;
         rest = bits % 64;
         for (int i = 0; i < full && i < SLOT_WORDS; i++)
            if (blocks[s*SLOT_WORDS + i] != '1) return 0;
         if (rest > 0 && full < SLOT_WORDS) begin
            m = (64'd1 << rest) - 64'd1;
            if ((blocks[s*SLOT_WORDS + full] & m) != m) return 0;
         end
         return 1;
      endfunction

      function verdict_type reassemble(fragment_type f);
         verdict_type v;
         int s;
         int hdr;
         int tot;
         int off;
         int plen;
         int b;
         bit hit;
         v.status = ST_PROGRESS;
         v.slot_index = '0;
         v.datagram_length = '0;
         s = find_slot(f);
         hdr = int'(f.header_words) * 4;
         tot = int'(f.total_length);
         off = int'(f.frag_offset) * 8;
         if (s < 0) begin
            v.status = ST_NOSLOT;
         end else begin
            v.slot_index = s[9:0];
            if (tot < hdr || off + (tot - hdr) > 65535) begin
               n_bounds++;
               active[s] = 0;
               v.status = ST_BOUNDS;
            end else begin
               plen = tot - hdr;
               hit = 0;
               for (int k = 0; k < (plen + 7) / 8; k++) begin
                  b = (int'(f.frag_offset) + k) & 8191;
                  if (blocks[s*SLOT_WORDS + (b >> 6)][b & 63]) hit = 1;
                  blocks[s*SLOT_WORDS + (b >> 6)][b & 63] = 1;
               end
               if (hit) begin
                  n_overlap++;
                  active[s] = 0;
                  v.status = ST_OVERLAP;
               end else begin
                  if (off == 0) have_first[s] = 1;
                  if (!f.more_fragments) begin
                     have_last[s] = 1;
                     exp_len[s] = 16'(off + plen);
                  end
                  if (have_first[s] && have_last[s] && covered(s, int'(exp_len[s]))) begin
                     n_complete++;
                     active[s] = 0;
                     v.datagram_length = exp_len[s];
                     v.status = ST_COMPLETE;
                  end
               end
            end
         end
         v.completed_count = n_complete;
         v.timeout_count = n_timeout;
         v.bounds_error_count = n_bounds;
         v.overlap_count = n_overlap;
         return v;
      endfunction

      function void note_fragment(fragment_type f);
         verdict_q.push_back(reassemble(f));
      endfunction

      function void match_field(string name, logic [31:0] exp, logic [31:0] got);
         if (got !== exp) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, exp, got);
            errors++;
         end
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type exp;
         if (verdict_q.size() == 0) begin
            $display("%0t unexpected result beat: expected none actual status %0d", $time,
                     got.status);
            errors++;
            return;
         end
         exp = verdict_q.pop_front();
         match_field("status", 32'(exp.status), 32'(got.status));
         match_field("slot_index", 32'(exp.slot_index), 32'(got.slot_index));
         match_field("datagram_length", 32'(exp.datagram_length), 32'(got.datagram_length));
         match_field("completed_count", exp.completed_count, got.completed_count);
         match_field("timeout_count", exp.timeout_count, got.timeout_count);
         match_field("bounds_error_count", exp.bounds_error_count, got.bounds_error_count);
         match_field("overlap_count", exp.overlap_count, got.overlap_count);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [31:0] csr_wr_data;

   ifrt_req_if req ();
   ifrt_rsp_if rsp ();

   ipv4_fragment_reassembly_tracker_top dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   reassembly_scoreboard sb = new();
   bit          quiet;
   bit          long_hold;
   bit [31:0]   wall_ms;
   int          sent;
   logic [31:0] key_src [6];
   logic [31:0] key_dst [6];
   logic [15:0] key_id [6];

   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #20_000_000;
      $display("[ipv4_fragment_reassembly_tracker_top] ERROR");
      $finish;
   end

   // receiver side: take beats, stall in bursts, or hold off for a long stretch
   initial begin
      int stall_left;
      stall_left = 0;
      rsp.ready <= 0;
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready)
            sb.check_verdict('{rsp.status, rsp.slot_index, rsp.datagram_length,
                               rsp.completed_count, rsp.timeout_count,
                               rsp.bounds_error_count, rsp.overlap_count});
         if (long_hold) begin
            long_hold = 0;
            rsp.ready <= 0;
            repeat (3000) @(posedge clock);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 12);
            rsp.ready <= 0;
         end else begin
            rsp.ready <= 1;
         end
      end
   end

   task automatic send_fragment(fragment_type f);
      req.valid <= 1;
      req.src_addr <= f.src_addr;
      req.dst_addr <= f.dst_addr;
      req.ip_id <= f.ip_id;
      req.protocol <= f.protocol;
      req.header_words <= f.header_words;
      req.total_length <= f.total_length;
      req.frag_offset <= f.frag_offset;
      req.more_fragments <= f.more_fragments;
      req.now_ms <= f.now_ms;
      do @(posedge clock); while (!req.ready);
      sb.note_fragment(f);
      sent++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req.valid <= 0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   function automatic fragment_type make_fragment(logic [31:0] src, logic [31:0] dst,
                                                 logic [15:0] id, logic [7:0] proto,
                                                 int offset, int plen, bit mf);
      fragment_type f;
      f.src_addr = src;
      f.dst_addr = dst;
      f.ip_id = id;
      f.protocol = proto;
      f.header_words = 4'd5;
      f.total_length = 16'(20 + plen);
      f.frag_offset = 13'(offset / 8);
      f.more_fragments = mf;
      f.now_ms = wall_ms;
      return f;
   endfunction

   task automatic drain();
      req.valid <= 0;
      while (sb.verdict_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_timeout(logic [31:0] value);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.timeout_ms = value;
      csr_wr_en <= 0;
   endtask

   // split one datagram into 8-byte aligned pieces, optionally shuffled or broken
   task automatic send_datagram(logic [31:0] src, logic [31:0] dst, logic [15:0] id,
                                logic [7:0] proto, int len, int pieces);
      fragment_type q [$];
      fragment_type t;
      int start;
      int sz;
      int j;
      int nblk;
      start = 0;
      nblk = (len + 7) / 8;
      if (len == 0) q.push_back(make_fragment(src, dst, id, proto, 0, 0, 0));
      while (start < len) begin
         sz = 8 * $urandom_range(1, nblk / pieces + 1);
         if (start + sz >= len) sz = len - start;
         q.push_back(make_fragment(src, dst, id, proto, start, sz, start + sz < len));
         start += sz;
      end
      if ($urandom_range(0, 9) < 7)
         for (int i = q.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = q[i];
            q[i] = q[j];
            q[j] = t;
         end
      case ($urandom_range(0, 9))
         0: if (q.size() > 1) q.delete($urandom_range(0, q.size() - 1));
         1: q.push_back(q[$urandom_range(0, q.size() - 1)]);
         2: q[0].header_words = 4'($urandom_range(0, 15));
         default: ;
      endcase
      foreach (q[i]) begin
         q[i].now_ms = wall_ms;
         send_fragment(q[i]);
         wall_ms += $urandom_range(0, 40);
      end
   endtask

   task automatic send_noise();
      fragment_type f;
      f.src_addr = $urandom;
      f.dst_addr = $urandom;
      f.ip_id = 16'($urandom);
      f.protocol = 8'($urandom);
      f.header_words = 4'($urandom);
      f.total_length = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 200));
      f.frag_offset = $urandom_range(0, 1) ? 13'($urandom) : 13'($urandom_range(0, 40));
      f.more_fragments = 1'($urandom);
      f.now_ms = $urandom_range(0, 3) == 0 ? $urandom : wall_ms;
      send_fragment(f);
   endtask

   task automatic random_phase(int count);
      int k;
      int len;
      int target;
      target = sent + count;
      while (sent < target) begin
         if ($urandom_range(0, 6) == 0) begin
            send_noise();
         end else begin
            k = $urandom_range(0, 5);
            if ($urandom_range(0, 2) == 0) begin
               key_src[k] = $urandom;
               key_dst[k] = $urandom;
               key_id[k] = 16'($urandom);
            end
            len = $urandom_range(0, 19) == 0 ? $urandom_range(0, 65515)
                                             : $urandom_range(0, 400);
            send_datagram(key_src[k], key_dst[k], key_id[k] + 16'(sent), 8'($urandom),
                          len, $urandom_range(1, 5));
         end
         if ($urandom_range(0, 30) == 0) wall_ms += $urandom;
      end
   endtask

   initial begin
      fragment_type f;
      reset = 1;
      csr_wr_en = 0;
      csr_wr_data = '0;
      req.valid = 0;
      req.src_addr = '0;
      req.dst_addr = '0;
      req.ip_id = '0;
      req.protocol = '0;
      req.header_words = '0;
      req.total_length = '0;
      req.frag_offset = '0;
      req.more_fragments = 0;
      req.now_ms = '0;
      quiet = 0;
      long_hold = 0;
      sent = 0;
      wall_ms = 32'd1000;
      foreach (key_src[i]) begin
         key_src[i] = $urandom;
         key_dst[i] = $urandom;
         key_id[i] = 16'($urandom);
      end
      repeat (9) @(posedge clock);
      reset <= 0;

      // single unfragmented datagram, then empty payload
      send_fragment(make_fragment(32'h0a000001, 32'h0a000002, 16'h0001, 8'd17, 0, 100, 0));
      send_fragment(make_fragment(32'h0a000003, 32'h0a000002, 16'h0002, 8'd6, 0, 0, 0));
      // header longer than total length
      f = make_fragment(32'h0a000004, 32'h0a000002, 16'h0003, 8'd6, 0, 0, 0);
      f.header_words = 4'd15;
      f.total_length = 16'd10;
      send_fragment(f);
      // offset beyond the datagram limit
      send_fragment(make_fragment(32'h0a000005, 32'h0a000002, 16'h0004, 8'd6, 65528, 16, 1));
      // last offset with empty payload stays in bounds
      send_fragment(make_fragment(32'h0a000006, 32'h0a000002, 16'h0005, 8'd6, 65528, 0, 1));
      // two pieces complete
      send_fragment(make_fragment(32'h0a000007, 32'h0a000002, 16'h0006, 8'd6, 0, 16, 1));
      send_fragment(make_fragment(32'h0a000007, 32'h0a000002, 16'h0006, 8'd6, 16, 5, 0));
      // overlap
      send_fragment(make_fragment(32'h0a000008, 32'h0a000002, 16'h0007, 8'd6, 0, 16, 1));
      send_fragment(make_fragment(32'h0a000008, 32'h0a000002, 16'h0007, 8'd6, 8, 16, 1));
      // nine datagrams on one home slot: the ninth finds no slot
      for (int i = 0; i < 9; i++)
         send_fragment(make_fragment(32'(i) << 16, 32'(i) << 16, 16'h0100, 8'd1, 0, 8, 1));
      // all fields at their maximum
      f.src_addr = '1;
      f.dst_addr = '1;
      f.ip_id = '1;
      f.protocol = '1;
      f.header_words = '1;
      f.total_length = '1;
      f.frag_offset = '0;
      f.more_fragments = 0;
      f.now_ms = '1;
      send_fragment(f);

      // zero timeout lets the waiting slots be reclaimed
      write_timeout(32'd0);
      wall_ms += 5;
      for (int i = 9; i < 12; i++)
         send_fragment(make_fragment(32'(i) << 16, 32'(i) << 16, 16'h0100, 8'd1, 0, 8, 1));
      random_phase(120);

      write_timeout(32'hffffffff);
      long_hold = 1;
      random_phase(150);

      write_timeout($urandom_range(0, 300));
      random_phase(80);
      // pause until every result is back, then carry on
      drain();
      random_phase(70);

      write_timeout(TIMEOUT_RESET);
      random_phase(80);
      quiet = 1;
      random_phase(100);

      drain();
      repeat (600) @(posedge clock);
      if (sb.errors == 0 && sb.verdict_q.size() == 0)
         $display("[ipv4_fragment_reassembly_tracker_top] OK");
      else
         $display("[ipv4_fragment_reassembly_tracker_top] ERROR");
      $finish;
   end

endmodule
